[rtl/core/siphash_cbc_mac_top_macros.svh]
// ============================================================================
// siphash_cbc_mac_top_macros.svh
// assertion macros shared by the siphash cbc-mac modules
// ============================================================================
`ifndef SIPHASH_CBC_MAC_TOP_MACROS_SVH
`define SIPHASH_CBC_MAC_TOP_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define SHMAC_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define SHMAC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/shmac_pkg.sv]
// ============================================================================
// shmac_pkg
// types, constants and round function of the siphash cbc-mac block
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package shmac_pkg;

    // input action codes
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_BYTE   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    // siphash initialization constants
    localparam logic [63:0] SIP_IV0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_IV1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_IV2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_IV3 = 64'h7465646279746573;
    localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;

    // rounds: 2 compression, then 4 finalization
    localparam int unsigned COMP_ROUNDS  = 2;
    localparam int unsigned TOTAL_ROUNDS = 6;
    localparam int unsigned RCNT_W       = $clog2(TOTAL_ROUNDS);

    // command queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_BLOCK,
        OP_FINISH
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [63:0] data;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } sip_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_ROUND
    } bk_state_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned sh);
        rotl64 = (x << sh) | (x >> (64 - sh));
    endfunction

    function automatic sip_state_t sip_round(input sip_state_t v);
        sip_state_t r;
        r = v;
        r.a = r.a + r.b; r.b = rotl64(r.b, 13); r.b = r.b ^ r.a; r.a = rotl64(r.a, 32);
        r.c = r.c + r.d; r.d = rotl64(r.d, 16); r.d = r.d ^ r.c;
        r.a = r.a + r.d; r.d = rotl64(r.d, 21); r.d = r.d ^ r.a;
        r.c = r.c + r.b; r.b = rotl64(r.b, 17); r.b = r.b ^ r.c; r.c = rotl64(r.c, 32);
        sip_round = r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/shmac_front.sv]
// ============================================================================
// shmac_front
// gathers message bytes into blocks and turns items into engine commands
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module shmac_front
    import shmac_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [63:0] s_chain_value,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        q_full,
    output q_push_t          push
);

    logic [55:0] pending_reg, pending_next;
    logic [2:0]  fill_reg, fill_next;
    logic [7:0]  len_reg, len_next;
    logic        accept;
    logic [55:0] pending_ins;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // byte lane insert at the current fill position
    always_comb begin
        pending_ins = pending_reg;
        for (int i = 0; i < 7; i++) begin
            if (fill_reg == 3'(i)) begin
                pending_ins[8*i +: 8] = s_data_byte;
            end
        end
    end

    always_comb begin
        pending_next = pending_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        push         = '0;
        push.entry.kind = OP_LOAD;
        if (accept) begin
            unique case (s_action)
                ACT_LOAD: begin
                    push.valid      = 1'b1;
                    push.entry.kind = OP_LOAD;
                    push.entry.data = s_chain_value;
                end
                ACT_BYTE: begin
                    len_next = len_reg + 8'd1;
                    if (fill_reg == 3'd7) begin
                        push.valid      = 1'b1;
                        push.entry.kind = OP_BLOCK;
                        push.entry.data = {s_data_byte, pending_reg};
                        pending_next    = '0;
                        fill_next       = '0;
                    end else begin
                        pending_next = pending_ins;
                        fill_next    = fill_reg + 3'd1;
                    end
                end
                ACT_FINISH: begin
                    push.valid      = 1'b1;
                    push.entry.kind = OP_FINISH;
                    push.entry.data = {len_reg, pending_reg};
                    pending_next    = '0;
                    fill_next       = '0;
                    len_next        = '0;
                end
                default: begin
                    // unused code, dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            fill_reg    <= '0;
            len_reg     <= '0;
        end else begin
            pending_reg <= pending_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/shmac_queue.sv]
// ============================================================================
// shmac_queue
// short command fifo between the front end and the compression engine
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "siphash_cbc_mac_top_macros.svh"

module shmac_queue
    import shmac_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire q_push_t push,
    input  wire logic    pop,
    output logic         q_valid,
    output logic         q_full,
    output q_entry_t     head
);

    q_entry_t         fifo_mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             do_push, do_pop;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == (QAW+1)'(QDEPTH));
    assign head    = fifo_mem[rd_ptr_reg];
    assign do_push = push.valid && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (QAW+1)'(1);
            2'b01:   count_next = count_reg - (QAW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            fifo_mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SHMAC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= (QAW+1)'(QDEPTH), "fifo count overflow")
    `SHMAC_ASSERT_NOW(a_no_push_full, push.valid, !q_full, "command pushed into full fifo")
    `SHMAC_ASSERT_NEXT(a_pop_count, do_pop && !do_push, count_reg == $past(count_reg) - (QAW+1)'(1), "fifo count did not drop on pop")

endmodule

`default_nettype wire

[rtl/core/shmac_back.sv]
// ============================================================================
// shmac_back
// siphash-2-4 compression engine, chain register and mac output register
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "siphash_cbc_mac_top_macros.svh"

module shmac_back
    import shmac_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire q_entry_t    head,
    output logic             pop,
    input  wire logic [63:0] key_low,
    input  wire logic [63:0] key_high,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_mac
);

    bk_state_t         state_reg, state_next;
    logic [RCNT_W-1:0] cnt_reg;
    sip_state_t        v_reg;
    logic [63:0]       m_reg;
    logic              emit_reg;
    logic [63:0]       chain_reg;
    logic [63:0]       mac_reg;
    logic              m_valid_reg;

    logic        idle;
    logic        last_round;
    logic        out_free;
    logic        can_pop;
    logic        start_comp;
    sip_state_t  v_init;
    sip_state_t  v_round;
    logic [63:0] fold;
    logic [63:0] m_in;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (start_comp) state_next = BK_ROUND;
            BK_ROUND: if (last_round) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        idle = 1'b0;
        unique case (state_reg)
            BK_IDLE:  idle = 1'b1;
            BK_ROUND: idle = 1'b0;
            default:  idle = 1'b0;
        endcase
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign can_pop    = idle && ((head.kind != OP_FINISH) || out_free);
    assign pop        = q_valid && can_pop;
    assign start_comp = pop && (head.kind != OP_LOAD);
    assign last_round = (cnt_reg == RCNT_W'(TOTAL_ROUNDS - 1));

    assign m_in     = head.data ^ chain_reg;
    assign v_init.a = SIP_IV0 ^ key_low;
    assign v_init.b = SIP_IV1 ^ key_high;
    assign v_init.c = SIP_IV2 ^ key_low;
    assign v_init.d = SIP_IV3 ^ key_high ^ m_in;

    // one round a cycle, finalization xors after the last compression round
    always_comb begin
        v_round = sip_round(v_reg);
        if (cnt_reg == RCNT_W'(COMP_ROUNDS - 1)) begin
            v_round.a = v_round.a ^ m_reg;
            v_round.c = v_round.c ^ SIP_FINAL_XOR;
        end
    end

    assign fold = v_round.a ^ v_round.b ^ v_round.c ^ v_round.d;

    always_ff @(posedge aclk) begin
        if (start_comp) begin
            v_reg    <= v_init;
            m_reg    <= m_in;
            emit_reg <= (head.kind == OP_FINISH);
        end else if (!idle) begin
            v_reg <= v_round;
        end
        if (!idle && last_round && emit_reg) begin
            mac_reg <= fold;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            cnt_reg     <= '0;
            chain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (start_comp) begin
                cnt_reg <= '0;
            end else if (!idle) begin
                cnt_reg <= cnt_reg + RCNT_W'(1);
            end
            if (pop && (head.kind == OP_LOAD)) begin
                chain_reg <= head.data;
            end else if (!idle && last_round) begin
                chain_reg <= fold;
            end
            if (!idle && last_round && emit_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_mac   = mac_reg;

    `SHMAC_ASSERT_NOW(a_pop_idle, pop, state_reg == BK_IDLE, "command taken while engine busy")
    `SHMAC_ASSERT_NOW(a_emit_slot_free, (state_reg == BK_ROUND) && last_round && emit_reg, !m_valid_reg, "mac finished into occupied output")
    `SHMAC_ASSERT_NEXT(a_round_start, start_comp, (state_reg == BK_ROUND) && (cnt_reg == '0), "compression did not start at round zero")

endmodule

`default_nettype wire

[rtl/core/siphash_cbc_mac_top.sv]
// ============================================================================
// siphash_cbc_mac_top
// cbc-mac over a byte stream with a siphash-2-4 block function
// ============================================================================
//
//   channel   ports                          moves
//   --------  -----------------------------  ---------------------------------
//   input     s_valid/s_ready, s_action,     one load, byte or finish transfer
//             s_chain_value, s_data_byte
//   result    m_valid/m_ready, m_mac         one mac per finish
//   config    psel/penable/pwrite/paddr      key_low at 0x0, key_high at 0x8
//
// - bytes are taken one per cycle while s_ready is high; the front end only
//   queues a command when a block completes, on a load and on a finish
// - the back end runs one siphash round per cycle: a block loads the lanes,
//   then runs six rounds; a load only replaces the chain
// - a finish's mac reaches m_mac through the command queue, the lane load and
//   the six rounds; it waits longer when earlier blocks are still queued
// - s_ready drops only while the 4-entry command queue is full; a waiting mac
//   holds a finish at the queue head, bytes and loads keep flowing until the
//   queue fills behind it
// - aresetn is synchronous, active low; keys, chain and counters go to zero,
//   no clearing pass
//
`timescale 1ns / 1ps
`default_nettype none

module siphash_cbc_mac_top
    import shmac_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [63:0] s_chain_value,
    input  wire logic [7:0]  s_data_byte,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_mac,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic        cfg_write;

    q_push_t  push;
    q_entry_t head;
    logic     q_valid;
    logic     q_full;
    logic     pop;

    // register access: bit 3 of the address picks the key half
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[3] ? key_high_reg : key_low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[3]) begin
                key_high_reg <= pwdata;
            end else begin
                key_low_reg <= pwdata;
            end
        end
    end

    // front end: byte packing, length count, command classification
    shmac_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_chain_value (s_chain_value),
        .s_data_byte   (s_data_byte),
        .q_full        (q_full),
        .push          (push)
    );

    // command queue decouples byte intake from compression
    shmac_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .q_valid (q_valid),
        .q_full  (q_full),
        .head    (head)
    );

    // back end: round engine, chain and mac output register
    shmac_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_mac    (m_mac)
    );

endmodule

`default_nettype wire

[dv/siphash_cbc_mac_top_test.sv]
// ============================================================================
// siphash_cbc_mac_top_test
// self-checking bench for the siphash-2-4 cbc-mac block: byte, load and finish
// transfers go in over a random-gap valid/ready channel, each mac coming back
// is compared against an in-bench cbc-mac predictor, keys are changed over the
// register port between idle phases
// ============================================================================
`timescale 1ns / 1ps

module siphash_cbc_mac_top_test;
    import shmac_pkg::*;

    // the block ignores the fourth action code
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    // register map: two 64-bit keys
    localparam logic [3:0] REG_KEY_LOW  = 4'h0;
    localparam logic [3:0] REG_KEY_HIGH = 4'h8;

    // a full command queue of blocks plus the mac path, with margin
    localparam int QUIET_CYCLES = 48;
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_LOAD;
    logic [63:0] s_chain_value = '0;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_mac;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    always #5 aclk = ~aclk;

    siphash_cbc_mac_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_chain_value (s_chain_value),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mac         (m_mac),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state, mirrors the block after every accepted transfer
    logic [63:0] key_lo_q = '0;
    logic [63:0] key_hi_q = '0;
    logic [63:0] chain_q = '0;
    logic [55:0] partial_q = '0;
    logic [2:0]  fill_q = '0;
    logic [7:0]  msg_len_q = '0;

    logic [63:0] mac_expected[$];
    int          err_count = 0;
    int          items_sent = 0;
    bit          no_idle = 1'b0;

    typedef struct {
        logic [63:0] v0, v1, v2, v3;
    } lanes_t;

    function automatic logic [63:0] rol(input logic [63:0] x, input int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic lanes_t sip_mix(input lanes_t s);
        lanes_t t;
        t = s;
        t.v0 = t.v0 + t.v1; t.v1 = rol(t.v1, 13) ^ t.v0; t.v0 = rol(t.v0, 32);
        t.v2 = t.v2 + t.v3; t.v3 = rol(t.v3, 16) ^ t.v2;
        t.v0 = t.v0 + t.v3; t.v3 = rol(t.v3, 21) ^ t.v0;
        t.v2 = t.v2 + t.v1; t.v1 = rol(t.v1, 17) ^ t.v2; t.v2 = rol(t.v2, 32);
        return t;
    endfunction

    // one cbc step: block xor chain through siphash-2-4, lanes folded
    function automatic logic [63:0] cbc_step(input logic [63:0] blk);
        lanes_t      s;
        logic [63:0] m;
        m = blk ^ chain_q;
        s.v0 = SIP_IV0 ^ key_lo_q;
        s.v1 = SIP_IV1 ^ key_hi_q;
        s.v2 = SIP_IV2 ^ key_lo_q;
        s.v3 = SIP_IV3 ^ key_hi_q ^ m;
        s = sip_mix(s);
        s = sip_mix(s);
        s.v0 = s.v0 ^ m;
        s.v2 = s.v2 ^ SIP_FINAL_XOR;
        for (int i = 0; i < 4; i++) s = sip_mix(s);
        return s.v0 ^ s.v1 ^ s.v2 ^ s.v3;
    endfunction

    function automatic void track_transfer(input logic [1:0] act, input logic [63:0] cv,
                                           input logic [7:0] byt);
        case (act)
            ACT_LOAD: begin
                chain_q = cv;
            end
            ACT_BYTE: begin
                msg_len_q = msg_len_q + 8'd1;
                if (fill_q == 3'd7) begin
                    // eighth byte closes the block
                    chain_q = cbc_step({byt, partial_q});
                    partial_q = '0;
                    fill_q = '0;
                end else begin
                    partial_q[8*fill_q +: 8] = byt;
                    fill_q = fill_q + 3'd1;
                end
            end
            ACT_FINISH: begin
                // zero padded tail with the length in the top byte
                chain_q = cbc_step({msg_len_q, partial_q});
                mac_expected.push_back(chain_q);
                partial_q = '0;
                fill_q = '0;
                msg_len_q = '0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom());
    endfunction

    // receiver stalls at random, with probability 0.38, unless idling is off
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= 38);
    end

    // result check; sampled mid-cycle so the handshake seen is the one the next edge takes
    always @(negedge aclk) begin : mac_check
        logic [63:0] want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (mac_expected.size() == 0) begin
                $error("mac: expected none, actual %h", m_mac);
                err_count++;
            end else begin
                want = mac_expected.pop_front();
                if (m_mac !== want) begin
                    $error("mac: expected %h, actual %h", want, m_mac);
                    err_count++;
                end
            end
        end
    end

    // called and returns on a rising edge; valid held until the transfer
    task automatic send_item(input logic [1:0] act, input logic [63:0] cv,
                             input logic [7:0] byt);
        int gap;
        bit taken;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_chain_value <= cv;
        s_data_byte <= byt;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = (s_ready === 1'b1);
            @(posedge aclk);
        end
        track_transfer(act, cv, byt);
        if (act != ACT_RESERVED) items_sent++;
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_KEY_LOW) key_lo_q = val;
        else key_hi_q = val;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (mac_expected.size() != 0) @(posedge aclk);
    endtask

    // block idle: all macs back and queued blocks worked off
    task automatic settle();
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic set_keys(input logic [63:0] k0, input logic [63:0] k1);
        settle();
        write_reg(REG_KEY_LOW, k0);
        write_reg(REG_KEY_HIGH, k1);
    endtask

    // random messages: mostly well formed with short lengths, some noise,
    // mid-message loads and a few messages left open into the next one
    task automatic run_messages(input int goal);
        int start_count;
        int len;
        int pick;
        start_count = items_sent;
        while (items_sent - start_count < goal) begin
            if ($urandom_range(0, 99) < 25) send_item(ACT_LOAD, rand64(), rand8());
            pick = $urandom_range(0, 99);
            if (pick < 80) len = $urandom_range(0, 16);
            else if (pick < 95) len = $urandom_range(17, 40);
            else len = $urandom_range(41, 90);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) send_item(ACT_RESERVED, rand64(), rand8());
                else if (pick < 5) send_item(ACT_LOAD, rand64(), rand8());
                send_item(ACT_BYTE, rand64(), rand8());
            end
            if ($urandom_range(0, 99) < 90) send_item(ACT_FINISH, rand64(), rand8());
        end
    endtask

    // zero keys and zero chain out of reset, empty message, ignored action
    task automatic test_reset_state();
        send_item(ACT_FINISH, '0, '0);
        send_item(ACT_RESERVED, ALL_ONES, 8'hff);
        send_item(ACT_FINISH, ALL_ONES, 8'hff);
    endtask

    task automatic test_directed_edges();
        set_keys(ALL_ONES, 64'h0123_4567_89ab_cdef);
        send_item(ACT_LOAD, '0, 8'hff);
        // full block of extreme bytes, then a finish with nothing pending
        send_item(ACT_BYTE, ALL_ONES, 8'h00);
        send_item(ACT_BYTE, '0, 8'hff);
        send_item(ACT_BYTE, '0, 8'h01);
        send_item(ACT_BYTE, '0, 8'h80);
        send_item(ACT_BYTE, '0, 8'h7f);
        send_item(ACT_BYTE, '0, 8'hfe);
        send_item(ACT_BYTE, '0, 8'h55);
        send_item(ACT_BYTE, '0, 8'haa);
        send_item(ACT_FINISH, '0, '0);
        // load in the middle of a message keeps the partial block
        send_item(ACT_LOAD, ALL_ONES, '0);
        send_item(ACT_BYTE, '0, 8'h00);
        send_item(ACT_BYTE, '0, 8'hff);
        send_item(ACT_LOAD, 64'ha5a5_5a5a_c3c3_3c3c, '0);
        send_item(ACT_BYTE, '0, 8'h3c);
        send_item(ACT_FINISH, ALL_ONES, 8'hff);
        // chain carries over as the next iv
        send_item(ACT_FINISH, '0, '0);
        send_item(ACT_RESERVED, ALL_ONES, 8'hff);
        send_item(ACT_FINISH, '0, '0);
    endtask

    task automatic test_random_traffic(input logic [63:0] k0, input logic [63:0] k1,
                                       input bit steady, input int goal);
        set_keys(k0, k1);
        no_idle = steady;
        run_messages(goal);
        no_idle = 1'b0;
    endtask

    // sender holds off mid-stream until every mac is back
    task automatic test_drain_pause();
        set_keys(rand64(), rand64());
        run_messages(100);
        wait_drained();
        @(posedge aclk);
        run_messages(100);
    endtask

    // length byte wraps modulo 256 on long messages
    task automatic test_length_wrap();
        int lens[4];
        set_keys('0, ALL_ONES);
        lens[0] = 255;
        lens[1] = 256;
        lens[2] = 263;
        lens[3] = $urandom_range(257, 320);
        foreach (lens[n]) begin
            send_item(ACT_LOAD, rand64(), '0);
            for (int i = 0; i < lens[n]; i++) send_item(ACT_BYTE, rand64(), rand8());
            send_item(ACT_FINISH, rand64(), rand8());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed_edges();
        test_random_traffic(rand64(), rand64(), 1'b1, 200);
        test_random_traffic(ALL_ONES, '0, 1'b0, 200);
        test_drain_pause();
        test_length_wrap();
        settle();
        if (err_count == 0) begin
            $display("siphash_cbc_mac_top_test: PASS");
        end else begin
            $display("siphash_cbc_mac_top_test: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("siphash_cbc_mac_top_test: FAIL");
        $finish;
    end

endmodule
